// ===== src/sts_pkg.sv =====
`default_nettype none
package sts_pkg;

   typedef enum logic [3:0] {
      M_IDLE, M_BANG, M_EQ, M_GT, M_LT, M_SLASH, M_COMMENT, M_STRING,
      M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_WORD
   } mode_type;

   localparam logic [5:0] K_LPAREN   = 6'd0;
   localparam logic [5:0] K_RPAREN   = 6'd1;
   localparam logic [5:0] K_LBRACE   = 6'd2;
   localparam logic [5:0] K_RBRACE   = 6'd3;
   localparam logic [5:0] K_COMMA    = 6'd4;
   localparam logic [5:0] K_DOT      = 6'd5;
   localparam logic [5:0] K_MINUS    = 6'd6;
   localparam logic [5:0] K_PLUS     = 6'd7;
   localparam logic [5:0] K_SEMI     = 6'd8;
   localparam logic [5:0] K_SLASH    = 6'd9;
   localparam logic [5:0] K_STAR     = 6'd10;
   localparam logic [5:0] K_NOT      = 6'd11;
   localparam logic [5:0] K_NOTEQ    = 6'd12;
   localparam logic [5:0] K_EQUAL    = 6'd13;
   localparam logic [5:0] K_EQEQ     = 6'd14;
   localparam logic [5:0] K_GREATER  = 6'd15;
   localparam logic [5:0] K_GREQ     = 6'd16;
   localparam logic [5:0] K_LESS     = 6'd17;
   localparam logic [5:0] K_LESSEQ   = 6'd18;
   localparam logic [5:0] K_STRING   = 6'd19;
   localparam logic [5:0] K_NUMBER   = 6'd20;
   localparam logic [5:0] K_IDENT    = 6'd21;
   localparam logic [5:0] K_KW0      = 6'd22;
   localparam logic [5:0] K_END      = 6'd38;
   localparam logic [5:0] K_ERR_STR  = 6'd39;
   localparam logic [5:0] K_ERR_CHAR = 6'd40;

   localparam int MAX_RES = 4;

   localparam logic [15:0][47:0] KW_TEXT = {
      48'h0065_6C69_6877, 48'h0000_0072_6176, 48'h0000_6575_7274, 48'h0000_7369_6874,
      48'h0072_6570_7573, 48'h6E72_7574_6572, 48'h0074_6E69_7270, 48'h0000_0000_726F,
      48'h0000_006C_696E, 48'h0000_0000_6669, 48'h0000_006E_7566, 48'h0000_0072_6F66,
      48'h0065_736C_6166, 48'h0000_6573_6C65, 48'h0073_7361_6C63, 48'h0000_0064_6E61
   };
   localparam logic [15:0][2:0] KW_LEN = {
      3'd5, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd2,
      3'd3, 3'd2, 3'd3, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3
   };

   typedef struct packed {
      logic [3:0][5:0]  kind;
      logic [3:0][15:0] start;
      logic [3:0][15:0] len;
      logic [3:0][15:0] line;
      logic [2:0]       cnt;
   } res_set_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "-");
   endfunction

   function automatic logic [5:0] word_kind(logic [47:0] chars, logic [2:0] len);
      logic [5:0] k;
      k = K_IDENT;
      for (int i = 15; i >= 0; i--) begin
         if ((KW_LEN[i] == len) && (KW_TEXT[i] == chars)) begin
            k = K_KW0 + 6'(i);
         end
      end
      return k;
   endfunction

   function automatic res_set_type put(res_set_type s, logic [5:0] k, logic [15:0] st,
                                       logic [15:0] ln, logic [15:0] line);
      res_set_type r;
      r = s;
      if (r.cnt < 3'd4) begin
         r.kind[r.cnt[1:0]]  = k;
         r.start[r.cnt[1:0]] = st;
         r.len[r.cnt[1:0]]   = ln;
         r.line[r.cnt[1:0]]  = line;
         r.cnt               = r.cnt + 3'd1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/script_token_scanner.sv =====
`default_nettype none
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  ch, last
// rsp_      out        rsp_valid/rsp_stall  kind, start_offset, length, line_no, final_res
//
// One byte per cycle is taken when not stalled; its tokens are computed in the same cycle.
// Up to four tokens per byte go into an 8-entry queue, read one per cycle unless stalled.
// req_stall rises while fewer than four queue entries are free.
// Reset is synchronous and clears the scanner state and the queue.
module script_token_scanner #(
   parameter int POS_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_kind,
   output logic [15:0]      rsp_start_offset,
   output logic [15:0]      rsp_length,
   output logic [15:0]      rsp_line_no,
   output logic             rsp_final_res
);

   localparam int PW = POS_BITS + 1;
   localparam int WW = (PW > 17) ? PW : 17;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam int DEPTH = 8;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic        fin;
   } entry_type;

   sts_pkg::mode_type     mode_ff, mode_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS_BITS-1:0]   ts_ff, ts_in;
   logic [15:0]           line_ff, line_in;
   logic [47:0]           word_ff, word_in;
   logic [2:0]            wlen_ff, wlen_in;
   sts_pkg::res_set_type  rs;

   entry_type             queue_ff [DEPTH];
   logic [2:0]            wr_ff, rd_ff;
   logic [3:0]            cnt_ff;
   logic                  push, pop;

   function automatic logic [15:0] sat16(logic [PW-1:0] v);
      if (WW'(v) > WW'(65535)) begin
         return 16'hFFFF;
      end
      return 16'(v);
   endfunction

   function automatic logic [PW-1:0] span(logic [PW-1:0] from, logic [PW-1:0] to);
      return (to > from) ? (to - from) : '0;
   endfunction

   always_comb begin
      logic             do_fresh;
      logic [PW-1:0]    pos, ts, endp;
      logic [7:0]       c;
      c        = req_ch;
      pos      = PW'(pos_ff);
      endp     = pos + PW'(1);
      ts       = PW'(ts_ff);
      mode_in  = mode_ff;
      ts_in    = ts_ff;
      line_in  = line_ff;
      word_in  = word_ff;
      wlen_in  = wlen_ff;
      rs       = '0;
      do_fresh = 1'b0;

      unique case (mode_ff)
         sts_pkg::M_BANG: begin
            if (c == "=") begin
               rs = sts_pkg::put(rs, sts_pkg::K_NOTEQ, sat16(ts), 16'd2, line_in);
               mode_in = sts_pkg::M_IDLE;
            end else begin
               rs = sts_pkg::put(rs, sts_pkg::K_NOT, sat16(ts), 16'd1, line_in);
               do_fresh = 1'b1;
            end
         end
         sts_pkg::M_EQ: begin
            priority if (c == "=") begin
               rs = sts_pkg::put(rs, sts_pkg::K_EQEQ, sat16(ts), 16'd2, line_in);
               mode_in = sts_pkg::M_IDLE;
            end else if (c == ">") begin
               rs = sts_pkg::put(rs, sts_pkg::K_GREQ, sat16(ts), 16'd2, line_in);
               mode_in = sts_pkg::M_IDLE;
            end else if (c == "<") begin
               rs = sts_pkg::put(rs, sts_pkg::K_LESSEQ, sat16(ts), 16'd2, line_in);
               mode_in = sts_pkg::M_IDLE;
            end else if (c == "!") begin
               rs = sts_pkg::put(rs, sts_pkg::K_NOTEQ, sat16(ts), 16'd2, line_in);
               mode_in = sts_pkg::M_IDLE;
            end else begin
               rs = sts_pkg::put(rs, sts_pkg::K_EQUAL, sat16(ts), 16'd1, line_in);
               do_fresh = 1'b1;
            end
         end
         sts_pkg::M_GT: begin
            if (c == "=") begin
               rs = sts_pkg::put(rs, sts_pkg::K_GREQ, sat16(ts), 16'd2, line_in);
               mode_in = sts_pkg::M_IDLE;
            end else begin
               rs = sts_pkg::put(rs, sts_pkg::K_GREATER, sat16(ts), 16'd1, line_in);
               do_fresh = 1'b1;
            end
         end
         sts_pkg::M_LT: begin
            if (c == "=") begin
               rs = sts_pkg::put(rs, sts_pkg::K_LESSEQ, sat16(ts), 16'd2, line_in);
               mode_in = sts_pkg::M_IDLE;
            end else begin
               rs = sts_pkg::put(rs, sts_pkg::K_LESS, sat16(ts), 16'd1, line_in);
               do_fresh = 1'b1;
            end
         end
         sts_pkg::M_SLASH: begin
            if (c == "/") begin
               mode_in = sts_pkg::M_COMMENT;
            end else begin
               rs = sts_pkg::put(rs, sts_pkg::K_SLASH, sat16(ts), 16'd1, line_in);
               do_fresh = 1'b1;
            end
         end
         sts_pkg::M_COMMENT: begin
            if (c == 8'h0A) begin
               if (line_in != 16'hFFFF) line_in = line_in + 16'd1;
               mode_in = sts_pkg::M_IDLE;
            end
         end
         sts_pkg::M_STRING: begin
            if (c == 8'h22) begin
               rs = sts_pkg::put(rs, sts_pkg::K_STRING, sat16(ts), sat16(span(ts, endp)),
                                 line_in);
               mode_in = sts_pkg::M_IDLE;
            end else if (c == 8'h0A) begin
               if (line_in != 16'hFFFF) line_in = line_in + 16'd1;
            end
         end
         sts_pkg::M_NUM_INT, sts_pkg::M_NUM_FRAC: begin
            if (sts_pkg::is_digit(c)) begin
            end else if ((c == ".") && (mode_ff == sts_pkg::M_NUM_INT)) begin
               mode_in = sts_pkg::M_NUM_DOT;
            end else begin
               rs = sts_pkg::put(rs, sts_pkg::K_NUMBER, sat16(ts), sat16(span(ts, pos)),
                                 line_in);
               do_fresh = 1'b1;
            end
         end
         sts_pkg::M_NUM_DOT: begin
            if (sts_pkg::is_digit(c)) begin
               mode_in = sts_pkg::M_NUM_FRAC;
            end else begin
               rs = sts_pkg::put(rs, sts_pkg::K_NUMBER, sat16(ts),
                                 sat16(span(ts, span(PW'(1), pos))), line_in);
               rs = sts_pkg::put(rs, sts_pkg::K_DOT, sat16(span(PW'(1), pos)), 16'd1,
                                 line_in);
               do_fresh = 1'b1;
            end
         end
         sts_pkg::M_WORD: begin
            if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c)) begin
               if (wlen_in < 3'd6) word_in[{wlen_in, 3'b000} +: 8] = c;
               if (wlen_in < 3'd7) wlen_in = wlen_in + 3'd1;
            end else begin
               rs = sts_pkg::put(rs, sts_pkg::word_kind(word_in, wlen_in), sat16(ts),
                                 sat16(span(ts, pos)), line_in);
               do_fresh = 1'b1;
            end
         end
         default: begin
            do_fresh = 1'b1;
         end
      endcase

      if (do_fresh) begin
         ts_in   = pos_ff;
         mode_in = sts_pkg::M_IDLE;
         priority case (c)
            "(": rs = sts_pkg::put(rs, sts_pkg::K_LPAREN, sat16(pos), 16'd1, line_in);
            ")": rs = sts_pkg::put(rs, sts_pkg::K_RPAREN, sat16(pos), 16'd1, line_in);
            "{": rs = sts_pkg::put(rs, sts_pkg::K_LBRACE, sat16(pos), 16'd1, line_in);
            "}": rs = sts_pkg::put(rs, sts_pkg::K_RBRACE, sat16(pos), 16'd1, line_in);
            ",": rs = sts_pkg::put(rs, sts_pkg::K_COMMA, sat16(pos), 16'd1, line_in);
            ".": rs = sts_pkg::put(rs, sts_pkg::K_DOT, sat16(pos), 16'd1, line_in);
            "-": rs = sts_pkg::put(rs, sts_pkg::K_MINUS, sat16(pos), 16'd1, line_in);
            "+": rs = sts_pkg::put(rs, sts_pkg::K_PLUS, sat16(pos), 16'd1, line_in);
            ";": rs = sts_pkg::put(rs, sts_pkg::K_SEMI, sat16(pos), 16'd1, line_in);
            "*": rs = sts_pkg::put(rs, sts_pkg::K_STAR, sat16(pos), 16'd1, line_in);
            "!": mode_in = sts_pkg::M_BANG;
            "=": mode_in = sts_pkg::M_EQ;
            ">": mode_in = sts_pkg::M_GT;
            "<": mode_in = sts_pkg::M_LT;
            "/": mode_in = sts_pkg::M_SLASH;
            8'h20, 8'h0D, 8'h09: begin
            end
            8'h0A: begin
               if (line_in != 16'hFFFF) line_in = line_in + 16'd1;
            end
            8'h22: mode_in = sts_pkg::M_STRING;
            default: begin
               priority if (sts_pkg::is_digit(c)) begin
                  mode_in = sts_pkg::M_NUM_INT;
               end else if (sts_pkg::is_alpha(c)) begin
                  mode_in = sts_pkg::M_WORD;
                  word_in = {40'd0, c};
                  wlen_in = 3'd1;
               end else begin
                  rs = sts_pkg::put(rs, sts_pkg::K_ERR_CHAR, sat16(pos), 16'd1, line_in);
               end
            end
         endcase
      end

      pos_in = (pos_ff != POS_MAX) ? pos_ff + 1'b1 : pos_ff;

      if (req_last) begin
         ts = PW'(ts_in);
         unique case (mode_in)
            sts_pkg::M_BANG:
               rs = sts_pkg::put(rs, sts_pkg::K_NOT, sat16(ts), 16'd1, line_in);
            sts_pkg::M_EQ:
               rs = sts_pkg::put(rs, sts_pkg::K_EQUAL, sat16(ts), 16'd1, line_in);
            sts_pkg::M_GT:
               rs = sts_pkg::put(rs, sts_pkg::K_GREATER, sat16(ts), 16'd1, line_in);
            sts_pkg::M_LT:
               rs = sts_pkg::put(rs, sts_pkg::K_LESS, sat16(ts), 16'd1, line_in);
            sts_pkg::M_SLASH:
               rs = sts_pkg::put(rs, sts_pkg::K_SLASH, sat16(ts), 16'd1, line_in);
            sts_pkg::M_STRING:
               rs = sts_pkg::put(rs, sts_pkg::K_ERR_STR, sat16(ts), sat16(span(ts, endp)),
                                 line_in);
            sts_pkg::M_NUM_INT, sts_pkg::M_NUM_FRAC:
               rs = sts_pkg::put(rs, sts_pkg::K_NUMBER, sat16(ts), sat16(span(ts, endp)),
                                 line_in);
            sts_pkg::M_NUM_DOT: begin
               rs = sts_pkg::put(rs, sts_pkg::K_NUMBER, sat16(ts), sat16(span(ts, pos)),
                                 line_in);
               rs = sts_pkg::put(rs, sts_pkg::K_DOT, sat16(pos), 16'd1, line_in);
            end
            sts_pkg::M_WORD:
               rs = sts_pkg::put(rs, sts_pkg::word_kind(word_in, wlen_in), sat16(ts),
                                 sat16(span(ts, endp)), line_in);
            default: begin
            end
         endcase
         rs      = sts_pkg::put(rs, sts_pkg::K_END, sat16(endp), 16'd0, line_in);
         mode_in = sts_pkg::M_IDLE;
         pos_in  = '0;
         ts_in   = '0;
         line_in = 16'd1;
         word_in = '0;
         wlen_in = '0;
      end
   end

   assign push      = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = (cnt_ff > 4'(DEPTH - sts_pkg::MAX_RES));
   assign rsp_valid = (cnt_ff != 4'd0);

   always_comb begin
      rsp_kind         = queue_ff[rd_ff].kind;
      rsp_start_offset = queue_ff[rd_ff].start;
      rsp_length       = queue_ff[rd_ff].len;
      rsp_line_no      = queue_ff[rd_ff].line;
      rsp_final_res    = queue_ff[rd_ff].fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sts_pkg::M_IDLE;
         pos_ff  <= '0;
         ts_ff   <= '0;
         line_ff <= 16'd1;
         word_ff <= '0;
         wlen_ff <= '0;
         wr_ff   <= '0;
         rd_ff   <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            mode_ff <= mode_in;
            pos_ff  <= pos_in;
            ts_ff   <= ts_in;
            line_ff <= line_in;
            word_ff <= word_in;
            wlen_ff <= wlen_in;
            wr_ff   <= wr_ff + rs.cnt;
         end
         if (pop) begin
            rd_ff <= rd_ff + 3'd1;
         end
         cnt_ff <= cnt_ff + (push ? {1'b0, rs.cnt} : 4'd0) - (pop ? 4'd1 : 4'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < sts_pkg::MAX_RES; i++) begin
            if (3'(i) < rs.cnt) begin
               queue_ff[wr_ff + 3'(i)] <= '{kind:  rs.kind[i],
                                            start: rs.start[i],
                                            len:   rs.len[i],
                                            line:  rs.line[i],
                                            fin:   (3'(i) == rs.cnt - 3'd1)};
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/sts_checker.sv =====
`default_nettype none
module sts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [5:0]  rsp_kind,
   input wire logic [15:0] rsp_length,
   input wire logic        rsp_final_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_length))
      else $error("Stalled result transaction changed.");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= sts_pkg::K_ERR_CHAR)
      else $error("Result kind out of range.");

   a_end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sts_pkg::K_END |-> rsp_length == 16'd0 && rsp_final_res)
      else $error("End token malformed.");

   a_punct_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind <= sts_pkg::K_NOT |-> rsp_length == 16'd1)
      else $error("Single-character token with wrong length.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("Queue not empty after reset.");

endmodule

bind script_token_scanner sts_checker u_sts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_length    (rsp_length),
   .rsp_final_res (rsp_final_res)
);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

   localparam int POS_MAX = 65535;
   localparam int LIMIT = 2000000;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } src_byte_type;

   typedef struct {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic        fin;
   } token_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_ch = 0;
   logic        req_last = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [5:0]  rsp_kind;
   logic [15:0] rsp_start_offset;
   logic [15:0] rsp_length;
   logic [15:0] rsp_line_no;
   logic        rsp_final_res;

   script_token_scanner dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_ch(req_ch), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind), .rsp_start_offset(rsp_start_offset),
      .rsp_length(rsp_length), .rsp_line_no(rsp_line_no),
      .rsp_final_res(rsp_final_res)
   );

   always #5 clock = ~clock;

   src_byte_type source_bytes[$];
   logic [7:0]   text_buf[$];
   token_type    expected_tokens[$];
   int           errors = 0;
   int           cycles = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           recv_hold = 0;
   logic         req_taken = 0;

   string keywords[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                           "or", "print", "return", "super", "this", "true", "var",
                           "while"};

   sts_pkg::mode_type scan_mode;
   int unsigned scan_pos;
   int unsigned tok_start;
   int unsigned line_cnt;
   logic [47:0] word_text;
   int          word_cnt;
   int          byte_tokens;

   function automatic int unsigned span(int unsigned from, int unsigned upto);
      return upto > from ? upto - from : 0;
   endfunction

   function automatic logic [15:0] clamp16(int unsigned v);
      return v > 65535 ? 16'hFFFF : 16'(v);
   endfunction

   function automatic logic chr_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic chr_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "-";
   endfunction

   function automatic logic [5:0] classify_word(logic [47:0] text, int n);
      logic [47:0] packed_kw;
      for (int k = 0; k < 16; k++) begin
         packed_kw = 0;
         for (int i = 0; i < keywords[k].len(); i++) begin
            packed_kw |= 48'(keywords[k][i]) << (8 * i);
         end
         if (keywords[k].len() == n && packed_kw == text) begin
            return sts_pkg::K_KW0 + 6'(k);
         end
      end
      return sts_pkg::K_IDENT;
   endfunction

   task automatic push_token(logic [5:0] k, int unsigned st, int unsigned ln);
      token_type t;
      if (byte_tokens >= sts_pkg::MAX_RES) return;
      t.kind = k;
      t.start = clamp16(st);
      t.len = clamp16(ln);
      t.line = line_cnt[15:0];
      t.fin = 0;
      expected_tokens.push_back(t);
      byte_tokens++;
   endtask

   task automatic clear_scanner();
      scan_mode = sts_pkg::M_IDLE;
      scan_pos = 0;
      tok_start = 0;
      line_cnt = 1;
      word_text = 0;
      word_cnt = 0;
   endtask

   task automatic append_word(logic [7:0] c);
      if (word_cnt < 6) word_text |= 48'(c) << (8 * word_cnt);
      if (word_cnt < 7) word_cnt++;
   endtask

   task automatic start_token(logic [7:0] c, int unsigned p);
      tok_start = p;
      scan_mode = sts_pkg::M_IDLE;
      case (c)
         "(": push_token(sts_pkg::K_LPAREN, p, 1);
         ")": push_token(sts_pkg::K_RPAREN, p, 1);
         "{": push_token(sts_pkg::K_LBRACE, p, 1);
         "}": push_token(sts_pkg::K_RBRACE, p, 1);
         ",": push_token(sts_pkg::K_COMMA, p, 1);
         ".": push_token(sts_pkg::K_DOT, p, 1);
         "-": push_token(sts_pkg::K_MINUS, p, 1);
         "+": push_token(sts_pkg::K_PLUS, p, 1);
         ";": push_token(sts_pkg::K_SEMI, p, 1);
         "*": push_token(sts_pkg::K_STAR, p, 1);
         "!": scan_mode = sts_pkg::M_BANG;
         "=": scan_mode = sts_pkg::M_EQ;
         ">": scan_mode = sts_pkg::M_GT;
         "<": scan_mode = sts_pkg::M_LT;
         "/": scan_mode = sts_pkg::M_SLASH;
         " ", 8'h0D, 8'h09: ;
         8'h0A: if (line_cnt < 65535) line_cnt++;
         8'h22: scan_mode = sts_pkg::M_STRING;
         default: begin
            if (chr_digit(c)) begin
               scan_mode = sts_pkg::M_NUM_INT;
            end else if (chr_letter(c)) begin
               scan_mode = sts_pkg::M_WORD;
               word_text = 0;
               word_cnt = 0;
               append_word(c);
            end else begin
               push_token(sts_pkg::K_ERR_CHAR, p, 1);
            end
         end
      endcase
   endtask

   task automatic scan_byte(logic [7:0] c, logic is_last);
      int unsigned p, ts, stop;
      p = scan_pos;
      ts = tok_start;
      stop = p + 1;
      byte_tokens = 0;
      case (scan_mode)
         sts_pkg::M_BANG:
            if (c == "=") begin
               push_token(sts_pkg::K_NOTEQ, ts, 2);
               scan_mode = sts_pkg::M_IDLE;
            end else begin
               push_token(sts_pkg::K_NOT, ts, 1);
               start_token(c, p);
            end
         sts_pkg::M_EQ:
            if (c == "=" || c == ">" || c == "<" || c == "!") begin
               push_token(c == "=" ? sts_pkg::K_EQEQ : c == ">" ? sts_pkg::K_GREQ
                          : c == "<" ? sts_pkg::K_LESSEQ : sts_pkg::K_NOTEQ, ts, 2);
               scan_mode = sts_pkg::M_IDLE;
            end else begin
               push_token(sts_pkg::K_EQUAL, ts, 1);
               start_token(c, p);
            end
         sts_pkg::M_GT:
            if (c == "=") begin
               push_token(sts_pkg::K_GREQ, ts, 2);
               scan_mode = sts_pkg::M_IDLE;
            end else begin
               push_token(sts_pkg::K_GREATER, ts, 1);
               start_token(c, p);
            end
         sts_pkg::M_LT:
            if (c == "=") begin
               push_token(sts_pkg::K_LESSEQ, ts, 2);
               scan_mode = sts_pkg::M_IDLE;
            end else begin
               push_token(sts_pkg::K_LESS, ts, 1);
               start_token(c, p);
            end
         sts_pkg::M_SLASH:
            if (c == "/") begin
               scan_mode = sts_pkg::M_COMMENT;
            end else begin
               push_token(sts_pkg::K_SLASH, ts, 1);
               start_token(c, p);
            end
         sts_pkg::M_COMMENT:
            if (c == 8'h0A) begin
               if (line_cnt < 65535) line_cnt++;
               scan_mode = sts_pkg::M_IDLE;
            end
         sts_pkg::M_STRING:
            if (c == 8'h22) begin
               push_token(sts_pkg::K_STRING, ts, span(ts, stop));
               scan_mode = sts_pkg::M_IDLE;
            end else if (c == 8'h0A && line_cnt < 65535) begin
               line_cnt++;
            end
         sts_pkg::M_NUM_INT, sts_pkg::M_NUM_FRAC:
            if (chr_digit(c)) begin
            end else if (c == "." && scan_mode == sts_pkg::M_NUM_INT) begin
               scan_mode = sts_pkg::M_NUM_DOT;
            end else begin
               push_token(sts_pkg::K_NUMBER, ts, span(ts, p));
               start_token(c, p);
            end
         sts_pkg::M_NUM_DOT:
            if (chr_digit(c)) begin
               scan_mode = sts_pkg::M_NUM_FRAC;
            end else begin
               push_token(sts_pkg::K_NUMBER, ts, span(ts, span(1, p)));
               push_token(sts_pkg::K_DOT, span(1, p), 1);
               start_token(c, p);
            end
         sts_pkg::M_WORD:
            if (chr_letter(c) || chr_digit(c)) begin
               append_word(c);
            end else begin
               push_token(classify_word(word_text, word_cnt), ts, span(ts, p));
               start_token(c, p);
            end
         default: start_token(c, p);
      endcase
      if (scan_pos < POS_MAX) scan_pos++;
      if (is_last) begin
         ts = tok_start;
         case (scan_mode)
            sts_pkg::M_BANG: push_token(sts_pkg::K_NOT, ts, 1);
            sts_pkg::M_EQ: push_token(sts_pkg::K_EQUAL, ts, 1);
            sts_pkg::M_GT: push_token(sts_pkg::K_GREATER, ts, 1);
            sts_pkg::M_LT: push_token(sts_pkg::K_LESS, ts, 1);
            sts_pkg::M_SLASH: push_token(sts_pkg::K_SLASH, ts, 1);
            sts_pkg::M_STRING: push_token(sts_pkg::K_ERR_STR, ts, span(ts, stop));
            sts_pkg::M_NUM_INT, sts_pkg::M_NUM_FRAC:
               push_token(sts_pkg::K_NUMBER, ts, span(ts, stop));
            sts_pkg::M_NUM_DOT: begin
               push_token(sts_pkg::K_NUMBER, ts, span(ts, p));
               push_token(sts_pkg::K_DOT, p, 1);
            end
            sts_pkg::M_WORD:
               push_token(classify_word(word_text, word_cnt), ts, span(ts, stop));
            default: ;
         endcase
         push_token(sts_pkg::K_END, stop, 0);
         clear_scanner();
      end
      if (byte_tokens > 0) expected_tokens[expected_tokens.size() - 1].fin = 1;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   task automatic flush_source();
      src_byte_type b;
      for (int i = 0; i < text_buf.size(); i++) begin
         b.ch = text_buf[i];
         b.last = (i == text_buf.size() - 1);
         source_bytes.push_back(b);
      end
      text_buf.delete();
   endtask

   task automatic add_random_source(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 24))
            0: add_text("(");
            1: add_text(")");
            2: add_text("{}");
            3: add_text(",;");
            4: add_text(".");
            5: add_text("-+*");
            6: add_text("!");
            7: add_text("=");
            8: add_text("==");
            9: add_text($urandom_range(0, 1) ? "=>" : "=<");
            10: add_text($urandom_range(0, 1) ? "!=" : "=!");
            11: add_text($urandom_range(0, 1) ? ">=" : "<=");
            12: add_text($urandom_range(0, 1) ? ">" : "<");
            13: add_text("/");
            14: add_text("// note\n");
            15: add_text("\"ab\ncd\"");
            16: add_text($sformatf("%0d", $urandom_range(0, 999)));
            17: add_text($sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 9)));
            18: add_text($sformatf("%0d.", $urandom_range(0, 9)));
            19: add_text(keywords[$urandom_range(0, 15)]);
            20: add_text($urandom_range(0, 1) ? "foo-bar9" : "Xy");
            21: add_text(" ");
            22: add_text("\n");
            23: add_text("\t\r");
            default: text_buf.push_back(8'($urandom));
         endcase
      end
      flush_source();
   endtask

   task automatic wait_drained();
      while (source_bytes.size() != 0 || req_valid || expected_tokens.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) scan_byte(req_ch, req_last);
   end

   always @(negedge clock) begin
      logic         next_valid;
      src_byte_type b;
      next_valid = req_valid && !req_taken;
      if (!reset && !next_valid && source_bytes.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
         b = source_bytes.pop_front();
         req_ch <= b.ch;
         req_last <= b.last;
         next_valid = 1;
      end
      req_valid <= next_valid;
   end

   always @(negedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < recv_idle_pct;
      end
   end

   always @(posedge clock) begin
      token_type t;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $error("unexpected transaction kind=%0d", rsp_kind);
            errors++;
         end else begin
            t = expected_tokens.pop_front();
            if (rsp_kind !== t.kind) begin
               $error("kind: expected %0d, actual %0d", t.kind, rsp_kind);
               errors++;
            end
            if (rsp_start_offset !== t.start) begin
               $error("start_offset: expected %0d, actual %0d", t.start, rsp_start_offset);
               errors++;
            end
            if (rsp_length !== t.len) begin
               $error("length: expected %0d, actual %0d", t.len, rsp_length);
               errors++;
            end
            if (rsp_line_no !== t.line) begin
               $error("line_no: expected %0d, actual %0d", t.line, rsp_line_no);
               errors++;
            end
            if (rsp_final_res !== t.fin) begin
               $error("final_res: expected %0d, actual %0d", t.fin, rsp_final_res);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      clear_scanner();
      repeat (8) @(posedge clock);
      reset <= 0;

      add_text("(){},.-+;*! != = == => =< =! > >= < <= / //c\n");
      add_text("\"s\n\"7.5 8.x and or-x while1 whilex ?");
      flush_source();
      text_buf.push_back(8'h00);
      add_text("\"a");
      text_buf.push_back(8'h00);
      add_text("\"//");
      text_buf.push_back(8'h00);
      flush_source();
      add_text("\"open");
      flush_source();
      add_text("7.");
      flush_source();
      add_text("=");
      flush_source();
      add_text("x");
      flush_source();
      add_text("1.!");
      flush_source();
      text_buf.push_back(8'hFF);
      flush_source();

      send_idle_pct = 14;
      recv_idle_pct = 48;
      for (int i = 0; i < 5; i++) add_random_source($urandom_range(2, 6));
      wait_drained();

      send_idle_pct = 48;
      recv_idle_pct = 14;
      for (int i = 0; i < 5; i++) add_random_source($urandom_range(2, 6));
      recv_hold = 300;
      for (int i = 0; i < 2; i++) add_random_source(10);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 5; i++) add_random_source($urandom_range(2, 6));
      wait_drained();

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
src/sts_pkg.sv
src/script_token_scanner.sv
src/sts_checker.sv
test/tb_top.sv
